// ===== src/dfih_pkg.sv =====
`timescale 1ns / 1ps

package dfih_pkg;

    // fnv-1a 64 constants
    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
    localparam logic [8:0]  FNV_PRIME_LOW = 9'h1b3;
    localparam int          FNV_PRIME_SHIFT = 40;

    // stream separators
    localparam logic [7:0] SEP_LOW  = 8'h1f;
    localparam logic [7:0] SEP_HIGH = 8'h1e;

    // fixed prefix of the high stream, as byte codes
    localparam int PREFIX_LEN = 15;
    localparam logic [7:0] PREFIX_BYTES [PREFIX_LEN] = '{
        8'h68, 8'h61, 8'h66, 8'h2e, 8'h69, 8'h64, 8'h65, 8'h6e,
        8'h74, 8'h69, 8'h74, 8'h79, 8'h2e, 8'h76, 8'h31
    };

    // action codes carried on the input tuser
    typedef enum logic [1:0] {
        ACT_DOMAIN = 2'd0,
        ACT_TOKEN  = 2'd1,
        ACT_FINISH = 2'd2
    } action_t;

    // byte source of a hash update
    typedef enum logic [1:0] {
        BS_INPUT    = 2'd0,
        BS_SEP_LOW  = 2'd1,
        BS_SEP_HIGH = 2'd2,
        BS_BUFFER   = 2'd3
    } byte_sel_t;

    // sequencer jump conditions
    typedef enum logic [2:0] {
        JC_NEXT     = 3'd0,  // fall through to the next step
        JC_GOTO     = 3'd1,  // always jump to target
        JC_DISPATCH = 3'd2,  // wait for a transfer, then branch on its action
        JC_RD_DONE  = 3'd3,  // jump to target once the replay has caught up
        JC_WAIT_OUT = 3'd4   // hold while the output register is full, then target
    } jump_t;

    typedef logic [3:0] upc_t;

    // program step addresses
    localparam upc_t U_IDLE    = 4'd0;
    localparam upc_t U_D_STORE = 4'd1;
    localparam upc_t U_D_DROP  = 4'd2;
    localparam upc_t U_T_SEP   = 4'd3;
    localparam upc_t U_T_BYTE  = 4'd4;
    localparam upc_t U_F_SEP   = 4'd5;
    localparam upc_t U_F_LOOP  = 4'd6;
    localparam upc_t U_F_HASH  = 4'd7;
    localparam upc_t U_F_TAIL  = 4'd8;
    localparam upc_t U_F_EMIT  = 4'd9;

    // one control word per step
    typedef struct packed {
        logic      lo_en;
        byte_sel_t lo_sel;
        logic      hi_en;
        byte_sel_t hi_sel;
        logic      buf_wr;
        logic      cnt_inc;
        logic      set_started;
        logic      set_ovf;
        logic      rd_inc;
        logic      emit;
        jump_t     jump;
        upc_t      target;
    } ctrl_t;

    // one fnv-1a step: xor the byte, multiply by the prime mod 2^64
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x * {55'd0, FNV_PRIME_LOW}) + {x[63-FNV_PRIME_SHIFT:0], {FNV_PRIME_SHIFT{1'b0}}};
    endfunction

    // high stream state after the prefix, worked out at elaboration
    function automatic logic [63:0] prefix_state();
        logic [63:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < PREFIX_LEN; i++)
        begin
            h = fnv_step(h, PREFIX_BYTES[i]);
        end
        return h;
    endfunction

    localparam logic [63:0] HIGH_INIT = prefix_state();

    // microcode rom
    function automatic ctrl_t ucode(input upc_t pc);
        ctrl_t cw;
        cw = '0;
        unique case (pc)
            U_IDLE:
            begin
                cw.jump = JC_DISPATCH;
                cw.target = U_IDLE;
            end
            U_D_STORE:
            begin
                cw.lo_en = 1'b1;
                cw.lo_sel = BS_INPUT;
                cw.buf_wr = 1'b1;
                cw.cnt_inc = 1'b1;
                cw.jump = JC_GOTO;
                cw.target = U_IDLE;
            end
            U_D_DROP:
            begin
                cw.set_ovf = 1'b1;
                cw.jump = JC_GOTO;
                cw.target = U_IDLE;
            end
            U_T_SEP:
            begin
                cw.lo_en = 1'b1;
                cw.lo_sel = BS_SEP_LOW;
                cw.set_started = 1'b1;
                cw.jump = JC_NEXT;
            end
            U_T_BYTE:
            begin
                cw.lo_en = 1'b1;
                cw.lo_sel = BS_INPUT;
                cw.hi_en = 1'b1;
                cw.hi_sel = BS_INPUT;
                cw.jump = JC_GOTO;
                cw.target = U_IDLE;
            end
            U_F_SEP:
            begin
                cw.lo_en = 1'b1;
                cw.lo_sel = BS_SEP_LOW;
                cw.jump = JC_NEXT;
            end
            U_F_LOOP:
            begin
                cw.jump = JC_RD_DONE;
                cw.target = U_F_TAIL;
            end
            U_F_HASH:
            begin
                cw.hi_en = 1'b1;
                cw.hi_sel = BS_BUFFER;
                cw.rd_inc = 1'b1;
                cw.jump = JC_GOTO;
                cw.target = U_F_LOOP;
            end
            U_F_TAIL:
            begin
                cw.hi_en = 1'b1;
                cw.hi_sel = BS_SEP_HIGH;
                cw.jump = JC_NEXT;
            end
            U_F_EMIT:
            begin
                cw.emit = 1'b1;
                cw.jump = JC_WAIT_OUT;
                cw.target = U_IDLE;
            end
            default:
            begin
                cw.jump = JC_GOTO;
                cw.target = U_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== src/dual_fnv1a_identity_hash.sv =====
`timescale 1ns / 1ps

// Builds a 128-bit identity from a domain string and a token with two fnv-1a 64
// streams. Send domain bytes (tuser action 0), then token bytes (action 1), then
// one finish transfer (action 2); the finish yields one result on the master side
// (id_low, id_high, overflow flag) and returns the block to its start state.
// Action 3 is taken and ignored. Up to DOMAIN_MAX domain bytes are kept for the
// replay; later ones, and domain bytes after the first token byte, are dropped
// and raise the overflow flag. A short microprogram, one control word per cycle,
// does the work: each byte passes a dispatch step and a work step (the first
// token byte, and a finish without a token, add a low separator step); a finish
// replays each buffered byte with one buffer read and one hash step. The finish
// holds in its last step while an earlier result has not been taken.
module dual_fnv1a_identity_hash #(
    parameter int DOMAIN_MAX = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [1:0]   s_tuser,   // [1:0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] id_low, [127:64] id_high
    output logic         m_tuser    // [0] domain_overflow
);

    localparam int ADDR_W = (DOMAIN_MAX > 1) ? $clog2(DOMAIN_MAX) : 1;
    localparam int CNT_W  = $clog2(DOMAIN_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DOMAIN_MAX);

    dfih_pkg::upc_t  upc_reg, upc_next;
    dfih_pkg::ctrl_t cw;

    logic [63:0]      low_reg, low_next;
    logic [63:0]      high_reg, high_next;
    logic [7:0]       byte_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             started_reg, started_next;
    logic             ovf_reg, ovf_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [63:0]      id_low_reg, id_high_reg;
    logic             id_ovf_reg;

    logic             in_fire;
    logic             out_busy;
    logic             emit_fire;
    logic             rd_done;
    logic             dom_blocked;
    logic [7:0]       buf_data;
    logic [7:0]       lo_byte, hi_byte;
    logic [63:0]      lo_fnv, hi_fnv;
    logic [63:0]      id_low_fix;
    dfih_pkg::upc_t   dispatch_pc;

    // control word of the current step
    assign cw = dfih_pkg::ucode(upc_reg);

    assign s_tready    = (upc_reg == dfih_pkg::U_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign out_busy    = m_tvalid_reg && !m_tready;
    assign emit_fire   = cw.emit && !out_busy;
    assign rd_done     = (rd_idx_reg == cnt_reg);
    assign dom_blocked = started_reg || (cnt_reg == CNT_MAX);

    // domain buffer for the high stream replay
    dfih_ram #(
        .WIDTH (8),
        .DEPTH (DOMAIN_MAX)
    ) u_buf (
        .clk     (clk),
        .wr_en   (cw.buf_wr),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (byte_reg),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (buf_data)
    );

    // branch target taken on an accepted transfer
    always_comb
    begin
        priority if (dfih_pkg::action_t'(s_tuser) == dfih_pkg::ACT_DOMAIN)
        begin
            dispatch_pc = dom_blocked ? dfih_pkg::U_D_DROP : dfih_pkg::U_D_STORE;
        end
        else if (dfih_pkg::action_t'(s_tuser) == dfih_pkg::ACT_TOKEN)
        begin
            dispatch_pc = started_reg ? dfih_pkg::U_T_BYTE : dfih_pkg::U_T_SEP;
        end
        else if (dfih_pkg::action_t'(s_tuser) == dfih_pkg::ACT_FINISH)
        begin
            dispatch_pc = started_reg ? dfih_pkg::U_F_LOOP : dfih_pkg::U_F_SEP;
        end
        else
        begin
            dispatch_pc = dfih_pkg::U_IDLE;
        end
    end

    // step counter
    always_comb
    begin
        unique case (cw.jump)
            dfih_pkg::JC_NEXT:     upc_next = upc_reg + 4'd1;
            dfih_pkg::JC_GOTO:     upc_next = cw.target;
            dfih_pkg::JC_DISPATCH: upc_next = in_fire ? dispatch_pc : upc_reg;
            dfih_pkg::JC_RD_DONE:  upc_next = rd_done ? cw.target : upc_reg + 4'd1;
            dfih_pkg::JC_WAIT_OUT: upc_next = out_busy ? upc_reg : cw.target;
            default:               upc_next = dfih_pkg::U_IDLE;
        endcase
    end

    // byte sources of the two hash units
    always_comb
    begin
        unique case (cw.lo_sel)
            dfih_pkg::BS_INPUT:    lo_byte = byte_reg;
            dfih_pkg::BS_SEP_LOW:  lo_byte = dfih_pkg::SEP_LOW;
            dfih_pkg::BS_SEP_HIGH: lo_byte = dfih_pkg::SEP_HIGH;
            dfih_pkg::BS_BUFFER:   lo_byte = buf_data;
        endcase
        unique case (cw.hi_sel)
            dfih_pkg::BS_INPUT:    hi_byte = byte_reg;
            dfih_pkg::BS_SEP_LOW:  hi_byte = dfih_pkg::SEP_LOW;
            dfih_pkg::BS_SEP_HIGH: hi_byte = dfih_pkg::SEP_HIGH;
            dfih_pkg::BS_BUFFER:   hi_byte = buf_data;
        endcase
    end

    assign lo_fnv = dfih_pkg::fnv_step(low_reg, lo_byte);
    assign hi_fnv = dfih_pkg::fnv_step(high_reg, hi_byte);

    // a zero identity is replaced by low word one
    assign id_low_fix = ((low_reg == 64'd0) && (high_reg == 64'd0)) ? 64'd1 : low_reg;

    // datapath next state
    always_comb
    begin
        low_next      = cw.lo_en ? lo_fnv : low_reg;
        high_next     = cw.hi_en ? hi_fnv : high_reg;
        cnt_next      = cw.cnt_inc ? cnt_reg + CNT_W'(1) : cnt_reg;
        rd_idx_next   = cw.rd_inc ? rd_idx_reg + CNT_W'(1) : rd_idx_reg;
        started_next  = started_reg || cw.set_started;
        ovf_next      = ovf_reg || cw.set_ovf;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit_fire)
        begin
            low_next      = dfih_pkg::FNV_BASIS;
            high_next     = dfih_pkg::HIGH_INIT;
            cnt_next      = '0;
            rd_idx_next   = '0;
            started_next  = 1'b0;
            ovf_next      = 1'b0;
            m_tvalid_next = 1'b1;
        end
    end

    // control and hash state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg      <= dfih_pkg::U_IDLE;
            low_reg      <= dfih_pkg::FNV_BASIS;
            high_reg     <= dfih_pkg::HIGH_INIT;
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
            started_reg  <= 1'b0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            upc_reg      <= upc_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            cnt_reg      <= cnt_next;
            rd_idx_reg   <= rd_idx_next;
            started_reg  <= started_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // input byte and output result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= s_tdata;
        end
        if (emit_fire)
        begin
            id_low_reg  <= id_low_fix;
            id_high_reg <= high_reg;
            id_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {id_high_reg, id_low_reg};
    assign m_tuser  = id_ovf_reg;

    // buffer count never passes its depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("domain count above buffer depth");

    // replay never runs ahead of the buffered bytes
    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= cnt_reg)
        else $error("replay index past domain count");

    // buffer writes only while domain bytes are still taken
    a_wr_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cw.buf_wr |-> (!started_reg && (cnt_reg < CNT_MAX)))
        else $error("domain buffer written when blocked");

    // a result transfer never carries the all-zero identity
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata != 128'd0))
        else $error("zero identity emitted");

    // emitting a result returns the state to its start values
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (cnt_reg == '0) && !started_reg && !ovf_reg
                      && (low_reg == dfih_pkg::FNV_BASIS) && (upc_reg == dfih_pkg::U_IDLE))
        else $error("state not restarted after finish");

endmodule

// ===== src/dfih_ram.sv =====
`timescale 1ns / 1ps

module dfih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== dv/tb_dual_fnv1a_identity_hash.sv =====
`timescale 1ns / 1ps

module tb_dual_fnv1a_identity_hash;

    // buffer depth of the instance, and the action code the block ignores
    localparam int          DOMAIN_DEPTH = 32;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam logic [63:0] PRIME_64     = 64'h0000_0100_0000_01b3;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 120;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          RANDOM_ITEMS = 1100;

    typedef struct {
        logic [63:0] id_low;
        logic [63:0] id_high;
        logic        overflow;
    } identity_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic [1:0]   s_tuser = 2'd0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;

    // predictor state
    logic [63:0] low_acc;
    logic [63:0] high_acc;
    logic [63:0] high_start;
    logic [7:0]  dom_bytes [DOMAIN_DEPTH];
    int          dom_len;
    bit          token_seen;
    bit          dropped_seen;
    identity_t   pending_ids [$];

    int err_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int hold_order = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int stall_left = 0;

    dual_fnv1a_identity_hash DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one fnv-1a 64 step
    function automatic logic [63:0] fold_byte(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * PRIME_64;
    endfunction

    // gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(6, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // back to the start state of an identity
    task automatic clear_identity();
        low_acc = dfih_pkg::FNV_BASIS;
        high_acc = high_start;
        dom_len = 0;
        token_seen = 1'b0;
        dropped_seen = 1'b0;
    endtask

    // update the predictor with one accepted input transfer
    task automatic apply_transfer(input logic [1:0] act, input logic [7:0] b);
        identity_t id;
        case (act)
            dfih_pkg::ACT_DOMAIN:
            begin
                if (token_seen || dom_len >= DOMAIN_DEPTH)
                    dropped_seen = 1'b1;
                else
                begin
                    dom_bytes[dom_len] = b;
                    dom_len++;
                    low_acc = fold_byte(low_acc, b);
                end
            end
            dfih_pkg::ACT_TOKEN:
            begin
                if (!token_seen)
                begin
                    low_acc = fold_byte(low_acc, dfih_pkg::SEP_LOW);
                    token_seen = 1'b1;
                end
                low_acc = fold_byte(low_acc, b);
                high_acc = fold_byte(high_acc, b);
            end
            dfih_pkg::ACT_FINISH:
            begin
                id.id_low = token_seen ? low_acc : fold_byte(low_acc, dfih_pkg::SEP_LOW);
                id.id_high = high_acc;
                for (int i = 0; i < dom_len; i++)
                    id.id_high = fold_byte(id.id_high, dom_bytes[i]);
                id.id_high = fold_byte(id.id_high, dfih_pkg::SEP_HIGH);
                // an all-zero identity is not allowed
                if (id.id_low == 64'd0 && id.id_high == 64'd0)
                    id.id_low = 64'd1;
                id.overflow = dropped_seen;
                pending_ids.insert(pending_ids.size(), id);
                clear_identity();
            end
            default:
            begin
            end
        endcase
    endtask

    // offer one transfer and wait until it is taken
    task automatic send_item(input logic [1:0] act, input logic [7:0] b);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < tx_gap_pct)
            gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= act;
        do
            @(posedge clk);
        while (!s_tready);
        apply_transfer(act, b);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want,
                 cycle_count);
        err_count++;
    endtask

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_taken != hold_order)
        begin
            hold_taken <= hold_order;
            hold_left <= HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < rx_stall_pct)
        begin
            stall_left <= gap_len() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // compare each output transfer with the oldest predicted identity
    always @(posedge clk)
    begin
        identity_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_ids.size() == 0)
                report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            else
            begin
                want = pending_ids.pop_front();
                if (m_tdata[63:0] !== want.id_low)
                    report_mismatch("id_low", m_tdata[63:0], want.id_low);
                if (m_tdata[127:64] !== want.id_high)
                    report_mismatch("id_high", m_tdata[127:64], want.id_high);
                if (m_tuser !== want.overflow)
                    report_mismatch("domain_overflow", {63'd0, m_tuser},
                                    {63'd0, want.overflow});
            end
        end
    end

    // extremes of the bytes, every action and the named corner cases
    task automatic test_directed();
        tx_gap_pct = 30;
        rx_stall_pct = 30;
        // nothing but the separators
        send_item(dfih_pkg::ACT_FINISH, 8'hff);
        // extreme bytes in domain and token
        send_item(dfih_pkg::ACT_DOMAIN, 8'h00);
        send_item(dfih_pkg::ACT_DOMAIN, 8'hff);
        send_item(dfih_pkg::ACT_DOMAIN, 8'h61);
        send_item(dfih_pkg::ACT_TOKEN, 8'h00);
        send_item(dfih_pkg::ACT_TOKEN, 8'hff);
        send_item(dfih_pkg::ACT_FINISH, 8'h00);
        // empty token, unused action in the middle
        send_item(ACT_UNUSED, 8'hff);
        send_item(dfih_pkg::ACT_DOMAIN, 8'h5a);
        send_item(ACT_UNUSED, 8'h00);
        send_item(dfih_pkg::ACT_DOMAIN, 8'ha5);
        send_item(dfih_pkg::ACT_FINISH, 8'h5a);
        // token without domain
        send_item(dfih_pkg::ACT_TOKEN, 8'h41);
        send_item(dfih_pkg::ACT_TOKEN, 8'h42);
        send_item(dfih_pkg::ACT_FINISH, 8'ha5);
        // domain byte after the token is dropped
        send_item(dfih_pkg::ACT_DOMAIN, 8'h01);
        send_item(dfih_pkg::ACT_TOKEN, 8'h02);
        send_item(dfih_pkg::ACT_DOMAIN, 8'h03);
        send_item(ACT_UNUSED, 8'h80);
        send_item(dfih_pkg::ACT_TOKEN, 8'h04);
        send_item(dfih_pkg::ACT_FINISH, 8'h7f);
    endtask

    // exactly full domain buffer, then a full buffer with extra bytes
    task automatic test_domain_full();
        tx_gap_pct = 10;
        rx_stall_pct = 10;
        for (int i = 0; i < DOMAIN_DEPTH; i++)
            send_item(dfih_pkg::ACT_DOMAIN, pick_byte());
        send_item(dfih_pkg::ACT_TOKEN, pick_byte());
        send_item(dfih_pkg::ACT_FINISH, pick_byte());
        for (int i = 0; i < DOMAIN_DEPTH + 4; i++)
            send_item(dfih_pkg::ACT_DOMAIN, pick_byte());
        send_item(dfih_pkg::ACT_FINISH, pick_byte());
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        hold_order++;
        for (int n = 0; n < 4; n++)
        begin
            for (int i = 0; i < 4; i++)
                send_item(dfih_pkg::ACT_DOMAIN, pick_byte());
            for (int i = 0; i < 3; i++)
                send_item(dfih_pkg::ACT_TOKEN, pick_byte());
            send_item(dfih_pkg::ACT_FINISH, pick_byte());
        end
    endtask

    // sender stops until every identity has come out
    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (pending_ids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        send_item(dfih_pkg::ACT_DOMAIN, pick_byte());
        send_item(dfih_pkg::ACT_FINISH, pick_byte());
    endtask

    // random identities, mostly well formed, some noise
    task automatic test_random();
        int target;
        int dlen;
        int tlen;
        int r;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            // change the idling pattern every so often
            if ($urandom_range(0, 7) == 0)
            begin
                r = $urandom_range(0, 2);
                tx_gap_pct = (r == 0) ? 0 : (r == 1) ? 20 : 60;
                r = $urandom_range(0, 2);
                rx_stall_pct = (r == 0) ? 0 : (r == 1) ? 20 : 60;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // broken sequence of arbitrary actions
                r = $urandom_range(1, 6);
                for (int i = 0; i < r; i++)
                    send_item(2'($urandom_range(0, 3)), pick_byte());
            end
            else
            begin
                r = $urandom_range(0, 19);
                if (r < 12)
                    dlen = $urandom_range(0, 6);
                else if (r < 17)
                    dlen = $urandom_range(7, 31);
                else if (r < 19)
                    dlen = DOMAIN_DEPTH;
                else
                    dlen = $urandom_range(DOMAIN_DEPTH + 1, DOMAIN_DEPTH + 8);
                tlen = $urandom_range(0, 8);
                for (int i = 0; i < dlen; i++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(ACT_UNUSED, pick_byte());
                    send_item(dfih_pkg::ACT_DOMAIN, pick_byte());
                end
                for (int i = 0; i < tlen; i++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(dfih_pkg::ACT_DOMAIN, pick_byte());
                    if ($urandom_range(0, 15) == 0)
                        send_item(ACT_UNUSED, pick_byte());
                    send_item(dfih_pkg::ACT_TOKEN, pick_byte());
                end
            end
            send_item(dfih_pkg::ACT_FINISH, pick_byte());
        end
    endtask

    initial
    begin
        // high stream start value from the prefix bytes
        high_start = dfih_pkg::FNV_BASIS;
        for (int i = 0; i < dfih_pkg::PREFIX_LEN; i++)
            high_start = fold_byte(high_start, dfih_pkg::PREFIX_BYTES[i]);
        clear_identity();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_domain_full();
        test_backpressure();
        test_drain_pause();
        test_random();

        // drain and let the block settle
        s_tvalid <= 1'b0;
        while (pending_ids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
